// ===== hw/rtl/lzssd_pkg.sv =====
// Shared types and constants for the LZSS window decoder.
// No dependencies; imported by the parser, the output queue and the top level.
`default_nettype none

package lzssd_pkg;

  // Window geometry
  localparam int WIN_SIZE  = 4096;
  localparam int LOOKAHEAD = 16;
  localparam int WIN_AW    = $clog2(WIN_SIZE);
  localparam int FILL_W    = WIN_AW + 1;

  localparam logic [WIN_AW-1:0] WP_RESET  = WIN_AW'(WIN_SIZE - LOOKAHEAD);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_SIZE);

  // Reference lengths: nibble plus minimum match, 3 to 18
  localparam int MIN_MATCH = 3;
  localparam int LEN_W     = 5;

  // Command from the parser to the copy engine
  typedef struct packed {
    logic              lit;        // literal word accepted this cycle
    logic              ref_start;  // reference high word accepted this cycle
    logic [7:0]        data;       // literal value
    logic [WIN_AW-1:0] pos;        // reference start position
    logic [3:0]        len_m3;     // reference length minus three
  } ps_cmd_t;

  // Output queue status toward the copy engine
  typedef struct packed {
    logic [1:0] cnt;  // words held
    logic       pop;  // a word leaves this cycle
  } oq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lzssd_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Generic; used for the history window.
`default_nettype none

module lzssd_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lzssd_out_queue.sv =====
// Two-entry output queue for decoded words, drives the result channel.
// Depends on lzssd_pkg for the status struct.
`default_nettype none

module lzssd_out_queue
  import lzssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] push_byte,
  input  wire logic       push_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_byte,
  output logic            out_last_of_run,
  output oq_stat_t        stat
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [8:0] e0_r, e0_nxt;
  logic [8:0] e1_r, e1_nxt;
  logic       pop;
  logic [1:0] slot;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_byte        = e0_r[7:0];
  assign out_last_of_run = e0_r[8];
  assign stat.cnt = cnt_r;
  assign stat.pop = pop;

  // Shift on pop, then place the new word behind what remains
  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    slot    = cnt_r;
    if (pop) begin
      e0_nxt = e1_r;
      slot   = cnt_r - 2'd1;
    end
    if (push) begin
      if (slot == 2'd0) begin
        e0_nxt = {push_last, push_byte};
      end else begin
        e1_nxt = {push_last, push_byte};
      end
    end
    cnt_nxt = slot + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lzssd_parser.sv =====
// Compressed stream parser: flag words, literals and two-word references.
// Depends on lzssd_pkg for the command struct.
`default_nettype none

module lzssd_parser
  import lzssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       eng_idle,
  input  wire logic       lit_room,
  output ps_cmd_t         cmd
);

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] flag_r, flag_nxt;
  logic [3:0] left_r, left_nxt;
  logic [7:0] pos_lo_r, pos_lo_nxt;
  logic       acc;
  logic [3:0] left_dec;

  // A literal also needs a free queue slot
  assign in_ready = eng_idle && ((phase_r != PH_ITEM) || !flag_r[0] || lit_room);
  assign acc      = in_valid && in_ready;
  assign left_dec = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;

  always_comb begin
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    left_nxt      = left_r;
    pos_lo_nxt    = pos_lo_r;
    cmd.lit       = 1'b0;
    cmd.ref_start = 1'b0;
    cmd.data      = in_byte;
    cmd.pos       = {in_byte[7:4], pos_lo_r};
    cmd.len_m3    = in_byte[3:0];
    if (acc) begin
      case (phase_r)
        PH_ITEM: begin
          if (flag_r[0]) begin
            cmd.lit   = 1'b1;
            flag_nxt  = {1'b0, flag_r[7:1]};
            left_nxt  = left_dec;
            phase_nxt = (left_dec == 4'd0) ? PH_FLAG : PH_ITEM;
          end else begin
            pos_lo_nxt = in_byte;
            phase_nxt  = PH_HIGH;
          end
        end
        PH_HIGH: begin
          cmd.ref_start = 1'b1;
          flag_nxt      = {1'b0, flag_r[7:1]};
          left_nxt      = left_dec;
          phase_nxt     = (left_dec == 4'd0) ? PH_FLAG : PH_ITEM;
        end
        default: begin
          // Flag word, also the unused phase code
          flag_nxt  = in_byte;
          left_nxt  = 4'd8;
          phase_nxt = PH_ITEM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FLAG;
      flag_r   <= 8'd0;
      left_r   <= 4'd0;
      pos_lo_r <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      flag_r   <= flag_nxt;
      left_r   <= left_nxt;
      pos_lo_r <= pos_lo_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lzssd_window_decoder.sv =====
`default_nettype none
// Channel | Ports                                  | Direction
// in      | in_valid, in_ready, in_byte             | compressed words in
// out     | out_valid, out_ready, out_byte,         | decoded words out
//         | out_last_of_run                          |
// A reference is latched from its high word, then copies len (3..18) words, with
// one window read and one window write per cycle through the single window RAM
// while the output queue has room; the last read lands before the next word is taken.
// Reset needs no clearing pass: a fill count marks which window entries were written.
// Output stalls hold the copy engine once the two-entry output queue is full.
// Top level of the LZSS decoder; depends on lzssd_pkg, lzssd_ram,
// lzssd_out_queue and lzssd_parser.

module lzss_window_decoder
  import lzssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_byte,
  output logic            out_last_of_run
);

  ps_cmd_t  cmd;
  oq_stat_t oq;

  logic              busy_r, busy_nxt;
  logic [WIN_AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic              pend_r, pend_last_r;
  logic              hit_r, vld_r;
  logic [7:0]        fwd_r;
  logic [WIN_AW-1:0] wp_r;
  logic [FILL_W-1:0] fill_r;

  logic              issue;
  logic              eng_idle;
  logic              lit_room;
  logic              we;
  logic [7:0]        wdata;
  logic [7:0]        rdata;
  logic [7:0]        rd_val;
  logic [WIN_AW-1:0] rd_off;
  logic              rd_written;

  // Parser
  assign eng_idle = !busy_r && !pend_r;
  assign lit_room = (oq.cnt != 2'd2) || oq.pop;

  lzssd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .eng_idle (eng_idle),
    .lit_room (lit_room),
    .cmd      (cmd)
  );

  // Issue a read only if the queue can absorb it next cycle
  assign issue = busy_r &&
                 ({1'b0, oq.cnt} + {2'b00, pend_r} <= 3'd1 + {2'b00, oq.pop});

  // Resolve read data: forward a same-cycle write, zero for unwritten entries
  assign rd_val = hit_r ? fwd_r : (vld_r ? rdata : 8'd0);

  // Window write: literal or landed copy word
  assign we    = cmd.lit || pend_r;
  assign wdata = cmd.lit ? cmd.data : rd_val;

  assign rd_off     = rd_addr_r - WP_RESET;
  assign rd_written = ({1'b0, rd_off} < fill_r);

  lzssd_ram #(
    .AW (WIN_AW),
    .DW (8)
  ) u_window (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_addr_r),
    .rdata (rdata)
  );

  lzssd_out_queue u_out_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (we),
    .push_byte       (wdata),
    .push_last       (cmd.lit || pend_last_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .stat            (oq)
  );

  // Copy sequencer: load on a reference, advance one word per issued read
  always_comb begin
    busy_nxt    = busy_r;
    rd_addr_nxt = rd_addr_r;
    remain_nxt  = remain_r;
    if (cmd.ref_start) begin
      busy_nxt    = 1'b1;
      rd_addr_nxt = cmd.pos;
      remain_nxt  = {1'b0, cmd.len_m3} + LEN_W'(MIN_MATCH);
    end else if (issue) begin
      rd_addr_nxt = rd_addr_r + WIN_AW'(1);
      remain_nxt  = remain_r - LEN_W'(1);
      busy_nxt    = (remain_r != LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      wp_r        <= WP_RESET;
      fill_r      <= '0;
      remain_r    <= '0;
    end else begin
      busy_r      <= busy_nxt;
      remain_r    <= remain_nxt;
      pend_r      <= issue;
      pend_last_r <= issue && (remain_r == LEN_W'(1));
      if (we) begin
        wp_r <= wp_r + WIN_AW'(1);
        if (fill_r != FILL_FULL) begin
          fill_r <= fill_r + FILL_W'(1);
        end
      end
    end
  end

  // Read-side bookkeeping for forwarding and the unwritten check
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    hit_r     <= we && (wp_r == rd_addr_r);
    fwd_r     <= wdata;
    vld_r     <= rd_written;
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!busy_r && !pend_r))
    else $error("word accepted while copy in progress");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pend_last_r) |=> !pend_r)
    else $error("read landed after final copy word");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (remain_r != '0))
    else $error("copy busy with zero words left");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond window size");
`endif

endmodule

`default_nettype wire
